>>> hdl/plist_pkg.sv
package plist_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [FUNC_W-1:0] {
        F_INS_AT    = 3'd0,
        F_DEL_AT    = 3'd1,
        F_INS_FRONT = 3'd2,
        F_INS_BACK  = 3'd3,
        F_DEL_FRONT = 3'd4,
        F_DEL_BACK  = 3'd5,
        F_READOUT   = 3'd6
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        C_HOLD,
        C_INSERT,
        C_DELETE,
        C_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic [IDX_W-1:0]          idx;
        logic [IDX_W-1:0]          last;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctrl;

    typedef struct packed {
        t_status                   status;
        logic [COUNT_W-1:0]        element_count;
        logic                      has_value;
        logic signed [DATA_W-1:0]  element_value;
        logic                      last_of_run;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

>>> hdl/plist_if.sv
interface plist_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [plist_pkg::FUNC_W-1:0]           func;
    logic signed [plist_pkg::DATA_W-1:0]    value;
    logic [plist_pkg::POS_W-1:0]            position;

    modport source (output valid, func, value, position, input ready);
    modport sink (input valid, func, value, position, output ready);
endinterface

interface plist_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [plist_pkg::STAT_W-1:0]           status;
    logic [plist_pkg::COUNT_W-1:0]          element_count;
    logic                                   has_value;
    logic signed [plist_pkg::DATA_W-1:0]    element_value;
    logic                                   last_of_run;

    modport source (output valid, status, element_count, has_value, element_value,
                    last_of_run, input ready);
    modport sink (input valid, status, element_count, has_value, element_value,
                  last_of_run, output ready);
endinterface

>>> hdl/plist_cell.sv
module plist_cell (
    input  logic                                 i_clk,
    input  plist_pkg::t_cell_ctrl                i_ctrl,
    input  logic [plist_pkg::IDX_W-1:0]          i_index,
    input  logic signed [plist_pkg::DATA_W-1:0]  i_left,
    input  logic signed [plist_pkg::DATA_W-1:0]  i_right,
    input  logic signed [plist_pkg::DATA_W-1:0]  i_head,
    output logic signed [plist_pkg::DATA_W-1:0]  o_data
);

    logic signed [plist_pkg::DATA_W-1:0] r_data;
    logic signed [plist_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            plist_pkg::C_INSERT: begin
                if (i_index > i_ctrl.idx) begin
                    n_data = i_left;
                end else if (i_index == i_ctrl.idx) begin
                    n_data = i_ctrl.value;
                end
            end
            plist_pkg::C_DELETE: begin
                if (i_index >= i_ctrl.idx) begin
                    n_data = i_right;
                end
            end
            plist_pkg::C_ROTATE: begin
                // the cell at the tail takes the head back so the list closes into a ring
                if (i_index == i_ctrl.last) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> hdl/plist_chain.sv
module plist_chain (
    input  logic                                 i_clk,
    input  plist_pkg::t_cell_ctrl                i_ctrl,
    output logic signed [plist_pkg::DATA_W-1:0]  o_head
);

    logic signed [plist_pkg::DATA_W-1:0] w_data [plist_pkg::CAPACITY];

    for (genvar g = 0; g < plist_pkg::CAPACITY; g++) begin : g_cell
        logic signed [plist_pkg::DATA_W-1:0] w_left;
        logic signed [plist_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctrl.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == plist_pkg::CAPACITY - 1) begin : g_tail
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        plist_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_index (plist_pkg::IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

>>> hdl/positional_list_insert_delete_core.sv
// channel  | dir | handshake     | payload
// i_cmd    | in  | valid / ready | func, value, position
// o_rsp    | out | valid / ready | status, element_count, has_value, element_value,
//          |     |               | last_of_run
//
// insert and delete shift the cells from the target cell onward: one transaction per cycle
// while the output is not stalled, one response each, held in an output register so the next
// command can enter while the response is taken.
// readout rotates the chain one cell per cycle and streams the head until every held
// element is sent, during which no command is taken; an output stall freezes the rotation.
// reset (synchronous, active low) clears the count and the control state only.
module positional_list_insert_delete_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plist_cmd_if.sink    i_cmd,
    plist_rsp_if.source  o_rsp
);

    plist_pkg::t_state                  r_state;
    plist_pkg::t_state                  n_state;
    logic [plist_pkg::CNT_W-1:0]        r_count;
    logic [plist_pkg::CNT_W-1:0]        n_count;
    logic [plist_pkg::CNT_W-1:0]        r_rd_cnt;
    logic [plist_pkg::CNT_W-1:0]        n_rd_cnt;
    plist_pkg::t_rsp                    r_rsp;
    plist_pkg::t_rsp                    n_rsp;
    logic                               r_rsp_valid;
    logic                               n_rsp_valid;

    plist_pkg::t_cell_ctrl              w_ctrl;
    logic signed [plist_pkg::DATA_W-1:0] w_head;
    logic                               w_slot_free;
    logic                               w_accept;
    logic                               w_start_read;
    logic                               w_read_last;
    logic                               w_emit;
    logic                               w_full;
    logic                               w_empty;
    logic [plist_pkg::CMP_W-1:0]        w_pos;
    logic [plist_pkg::CMP_W-1:0]        w_cnt;

    assign w_slot_free = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == plist_pkg::CNT_W'(plist_pkg::CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_pos       = plist_pkg::CMP_W'(i_cmd.position);
    assign w_cnt       = plist_pkg::CMP_W'(r_count);
    assign w_read_last = (r_rd_cnt + plist_pkg::CNT_W'(1)) == r_count;

    plist_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .o_head (w_head)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plist_pkg::S_IDLE: begin
                if (w_start_read) begin
                    n_state = plist_pkg::S_READ;
                end
            end
            plist_pkg::S_READ: begin
                if (w_slot_free && w_read_last) begin
                    n_state = plist_pkg::S_IDLE;
                end
            end
            default: n_state = plist_pkg::S_IDLE;
        endcase
    end

    // outputs, command decode and chain control
    always_comb begin
        plist_pkg::t_status st;
        st              = plist_pkg::ST_OK;
        i_cmd.ready     = 1'b0;
        w_start_read    = 1'b0;
        w_emit          = 1'b0;
        w_ctrl.op       = plist_pkg::C_HOLD;
        w_ctrl.idx      = '0;
        w_ctrl.last     = plist_pkg::IDX_W'(r_count - plist_pkg::CNT_W'(1));
        w_ctrl.value    = i_cmd.value;
        n_count         = r_count;
        n_rd_cnt        = r_rd_cnt;
        n_rsp_valid     = r_rsp_valid && !o_rsp.ready;
        n_rsp           = r_rsp;

        unique case (r_state)
            plist_pkg::S_IDLE: begin
                i_cmd.ready = w_slot_free;
                unique case (i_cmd.func) inside
                    plist_pkg::F_INS_AT: begin
                        if (w_pos == '0 || w_pos > w_cnt + plist_pkg::CMP_W'(1)) begin
                            st = plist_pkg::ST_BADPOS;
                        end else if (w_full) begin
                            st = plist_pkg::ST_FULL;
                        end else begin
                            w_ctrl.op  = plist_pkg::C_INSERT;
                            w_ctrl.idx = plist_pkg::IDX_W'(w_pos - plist_pkg::CMP_W'(1));
                        end
                    end
                    plist_pkg::F_DEL_AT: begin
                        if (w_empty) begin
                            st = plist_pkg::ST_EMPTY;
                        end else if (w_pos == '0 || w_pos > w_cnt) begin
                            st = plist_pkg::ST_BADPOS;
                        end else begin
                            w_ctrl.op  = plist_pkg::C_DELETE;
                            w_ctrl.idx = plist_pkg::IDX_W'(w_pos - plist_pkg::CMP_W'(1));
                        end
                    end
                    plist_pkg::F_INS_FRONT, plist_pkg::F_INS_BACK: begin
                        if (w_full) begin
                            st = plist_pkg::ST_FULL;
                        end else begin
                            w_ctrl.op  = plist_pkg::C_INSERT;
                            w_ctrl.idx = (i_cmd.func == plist_pkg::F_INS_BACK) ?
                                         plist_pkg::IDX_W'(r_count) : '0;
                        end
                    end
                    plist_pkg::F_DEL_FRONT, plist_pkg::F_DEL_BACK: begin
                        if (w_empty) begin
                            st = plist_pkg::ST_EMPTY;
                        end else begin
                            w_ctrl.op  = plist_pkg::C_DELETE;
                            w_ctrl.idx = (i_cmd.func == plist_pkg::F_DEL_BACK) ?
                                plist_pkg::IDX_W'(r_count - plist_pkg::CNT_W'(1)) : '0;
                        end
                    end
                    plist_pkg::F_READOUT: begin
                        if (w_empty) begin
                            st = plist_pkg::ST_EMPTY;
                        end
                    end
                    default: st = plist_pkg::ST_OK;
                endcase

                if (!w_accept) begin
                    w_ctrl.op = plist_pkg::C_HOLD;
                end else if (i_cmd.func == plist_pkg::F_READOUT && !w_empty) begin
                    w_start_read = 1'b1;
                    n_rd_cnt     = '0;
                end else begin
                    if (w_ctrl.op == plist_pkg::C_INSERT) begin
                        n_count = r_count + plist_pkg::CNT_W'(1);
                    end else if (w_ctrl.op == plist_pkg::C_DELETE) begin
                        n_count = r_count - plist_pkg::CNT_W'(1);
                    end
                    n_rsp_valid           = 1'b1;
                    n_rsp.status          = st;
                    n_rsp.element_count   = plist_pkg::COUNT_W'(n_count);
                    n_rsp.has_value       = 1'b0;
                    n_rsp.element_value   = '0;
                    n_rsp.last_of_run     = 1'b1;
                end
            end
            plist_pkg::S_READ: begin
                if (w_slot_free) begin
                    w_emit                = 1'b1;
                    w_ctrl.op             = plist_pkg::C_ROTATE;
                    n_rd_cnt              = r_rd_cnt + plist_pkg::CNT_W'(1);
                    n_rsp_valid           = 1'b1;
                    n_rsp.status          = plist_pkg::ST_OK;
                    n_rsp.element_count   = plist_pkg::COUNT_W'(r_count);
                    n_rsp.has_value       = 1'b1;
                    n_rsp.element_value   = w_head;
                    n_rsp.last_of_run     = w_read_last;
                end
            end
            default: i_cmd.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plist_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_cnt    <= n_rd_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.element_count = r_rsp.element_count;
    assign o_rsp.has_value     = r_rsp.has_value;
    assign o_rsp.element_value = r_rsp.element_value;
    assign o_rsp.last_of_run   = r_rsp.last_of_run;

    a_no_cmd_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plist_pkg::S_READ) |-> !i_cmd.ready)
        else $error("command taken during readout");

    a_insert_counts_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctrl.op == plist_pkg::C_INSERT)
        |=> (r_count == $past(r_count) + plist_pkg::CNT_W'(1)))
        else $error("insert did not raise the count");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.status == plist_pkg::ST_FULL)
        |-> (r_count == plist_pkg::CNT_W'(plist_pkg::CAPACITY)))
        else $error("full status with room left");

    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.has_value) |-> (r_rsp.status == plist_pkg::ST_OK))
        else $error("listed element with error status");

    a_emit_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_rd_cnt < r_count))
        else $error("readout past the held elements");

endmodule
